### hdl/bae_pkg.sv
package bae_pkg;

    // Special byte values
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
    localparam logic [7:0] CHAR_QUOTE    = 8'h22;
    localparam logic [7:0] DELIM_RESET   = 8'h2C;

    // Split modes
    localparam logic MODE_BRACKET = 1'b0;
    localparam logic MODE_HIVE    = 1'b1;

    // Register indexes
    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    // Field status codes
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_FRAMING    = 3'd1;
    localparam logic [2:0] STATUS_UNBALANCED = 3'd2;
    localparam logic [2:0] STATUS_OPEN_QUOTE = 3'd3;
    localparam logic [2:0] STATUS_DEPTH_OVF  = 3'd4;

    // One input byte with its framing marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic       empty_field;
    } item_t;

    // One result
    typedef struct packed {
        logic        content;
        logic        ends_element;
        logic        done_res;
        logic [15:0] element_count;
        logic [2:0]  status;
    } result_t;

    // Single-bit field state
    typedef struct packed {
        logic quote_open;
        logic inner_nonempty;
        logic segment_nonempty;
        logic framing_bad;
        logic depth_overflow;
    } flags_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [7:0] delimiter;
        logic       mode;
    } cfg_t;

endpackage

### hdl/bracketed_array_element_splitter.sv
// Array-field element splitter.
// Slave stream: one byte of field text per transaction in s_tdata, s_tlast
// on the field's last byte, s_tuser carrying the first-byte and empty-field
// flags. Master stream: one result per input byte, with m_tuser flags
// telling whether the byte is element text or ends an element, m_tlast on
// the field's closing result, and the element count and field status in
// m_tdata. Delimiter and split mode are set over the APB port, and the user
// must set them while the block is idle; the block does not enforce this.
// Each byte lands in the input register when it is accepted, and its result
// then loads into the result register. Throughput: one byte per cycle while
// the receiver takes results; the only loop is the field state update, a
// single short combinational step.
// Reset clears the field state, empties both registers and restores the
// default delimiter (comma) and bracketed mode.
// When the receiver stalls, the result register holds, the input register
// still takes one more byte, and s_tready then drops until the result goes.
module bracketed_array_element_splitter
    import bae_pkg::*;
#(
    parameter int DEPTH_BITS = 8,
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last
    input  logic [1:0]  s_tuser,   // [0] first, [1] empty_field
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] element_count, [18:16] status, rest zero
    output logic        m_tlast,   // done_res
    output logic [1:0]  m_tuser    // [0] content, [1] ends_element
);

    cfg_t                  cfg;
    item_t                 item_reg;
    logic                  in_valid_reg;
    result_t               res_reg;
    logic                  out_valid_reg;
    flags_t                flags_reg;
    flags_t                flags_next;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    result_t               res_next;
    logic                  advance;
    logic                  s_accept;

    bae_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bae_step #(
        .DEPTH_BITS (DEPTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .item      (item_reg),
        .cfg       (cfg),
        .flags_in  (flags_reg),
        .depth_in  (depth_reg),
        .count_in  (count_reg),
        .flags_out (flags_next),
        .depth_out (depth_next),
        .count_out (count_next),
        .res       (res_next)
    );

    // Handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                depth_reg     <= depth_next;
                count_reg     <= count_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.data_byte   <= s_tdata;
            item_reg.first       <= s_tuser[0];
            item_reg.last        <= s_tlast;
            item_reg.empty_field <= s_tuser[1];
        end
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.status, res_reg.element_count};
    assign m_tlast  = res_reg.done_res;
    assign m_tuser  = {res_reg.ends_element, res_reg.content};

`ifndef ASSERT_OFF
    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[18:16] == STATUS_OK))
        else $error("nonzero status on a result that does not close a field");

    // only a closing byte in Hive mode can be both text and an element end
    a_boundary_not_content: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !(m_tuser[0] && m_tuser[1]))
        else $error("byte marked as both content and element end");

    a_state_clear_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.done_res) |=>
            (count_reg == '0 && depth_reg == '0 && flags_reg == '0))
        else $error("field state not cleared after closing result");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input register dropped an unprocessed byte");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

### hdl/bae_cfg.sv
module bae_cfg
    import bae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] delimiter_reg;
    logic       mode_reg;
    logic       wr_en;
    logic       reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
            mode_reg      <= MODE_BRACKET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_DELIMITER: delimiter_reg <= pwdata[7:0];
                REG_MODE:      mode_reg      <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_index)
            REG_DELIMITER: prdata = {24'd0, delimiter_reg};
            REG_MODE:      prdata = {31'd0, mode_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.delimiter = delimiter_reg;
    assign cfg.mode      = mode_reg;

endmodule

### hdl/bae_step.sv
module bae_step
    import bae_pkg::*;
#(
    parameter int DEPTH_BITS = 8,
    parameter int COUNT_BITS = 16
)
(
    input  item_t                  item,
    input  cfg_t                   cfg,
    input  flags_t                 flags_in,
    input  logic [DEPTH_BITS-1:0]  depth_in,
    input  logic [COUNT_BITS-1:0]  count_in,
    output flags_t                 flags_out,
    output logic [DEPTH_BITS-1:0]  depth_out,
    output logic [COUNT_BITS-1:0]  count_out,
    output result_t                res
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    flags_t                f;
    logic [DEPTH_BITS-1:0] depth;
    logic [COUNT_BITS-1:0] count_base;
    logic [COUNT_BITS-1:0] count_a;
    logic [COUNT_BITS-1:0] count_b;
    logic                  bump_a;
    logic                  bump_b;
    logic                  content;
    logic                  ends;
    logic                  done;
    logic                  is_delim;
    logic [2:0]            status;

    assign is_delim = (item.data_byte == cfg.delimiter);

    // Per-byte decision and state update
    always_comb
    begin
        f          = item.first ? '0 : flags_in;
        depth      = item.first ? '0 : depth_in;
        count_base = item.first ? '0 : count_in;
        content    = 1'b0;
        ends       = 1'b0;
        done       = 1'b0;
        bump_a     = 1'b0;
        bump_b     = 1'b0;
        if (item.empty_field)
        begin
            done = 1'b1;
            if (cfg.mode == MODE_BRACKET)
                f.framing_bad = 1'b1;
            else if (f.segment_nonempty)
            begin
                ends               = 1'b1;
                bump_a             = 1'b1;
                f.segment_nonempty = 1'b0;
            end
        end
        else if (cfg.mode == MODE_HIVE)
        begin
            if (is_delim)
            begin
                ends               = 1'b1;
                bump_a             = 1'b1;
                f.segment_nonempty = 1'b0;
            end
            else
            begin
                content            = 1'b1;
                f.segment_nonempty = 1'b1;
            end
            if (item.last)
            begin
                done = 1'b1;
                if (f.segment_nonempty)
                begin
                    ends               = 1'b1;
                    bump_b             = 1'b1;
                    f.segment_nonempty = 1'b0;
                end
            end
        end
        else if (item.first)
        begin
            // opening bracket
            if (item.data_byte != CHAR_LBRACKET)
                f.framing_bad = 1'b1;
            if (item.last)
            begin
                f.framing_bad = 1'b1;
                done          = 1'b1;
            end
        end
        else if (item.last)
        begin
            // closing bracket
            if (item.data_byte != CHAR_RBRACKET)
                f.framing_bad = 1'b1;
            ends = f.inner_nonempty;
            done = 1'b1;
        end
        else
        begin
            // inner byte
            if (!f.inner_nonempty)
            begin
                f.inner_nonempty = 1'b1;
                bump_a           = 1'b1;
            end
            content = 1'b1;
            if (item.data_byte == CHAR_QUOTE)
                f.quote_open = !f.quote_open;
            else if (!f.quote_open && item.data_byte == CHAR_LBRACKET)
            begin
                if (depth == DEPTH_MAX)
                    f.depth_overflow = 1'b1;
                else
                    depth = depth + 1'b1;
            end
            else if (!f.quote_open && item.data_byte == CHAR_RBRACKET)
            begin
                if (depth == DEPTH_MIN)
                    f.depth_overflow = 1'b1;
                else
                    depth = depth - 1'b1;
            end
            else if (!f.quote_open && depth == '0 && is_delim)
            begin
                content = 1'b0;
                ends    = 1'b1;
                bump_b  = 1'b1;
            end
        end
    end

    // Saturating count, up to two bumps per byte
    assign count_a = (bump_a && !(&count_base)) ? count_base + 1'b1 : count_base;
    assign count_b = (bump_b && !(&count_a)) ? count_a + 1'b1 : count_a;

    // Status by priority
    always_comb
    begin
        status = STATUS_OK;
        if (done && cfg.mode == MODE_BRACKET)
        begin
            if (f.framing_bad)
                status = STATUS_FRAMING;
            else if (f.depth_overflow)
                status = STATUS_DEPTH_OVF;
            else if (depth != '0)
                status = STATUS_UNBALANCED;
            else if (f.quote_open)
                status = STATUS_OPEN_QUOTE;
        end
    end

    // Field state clears after the closing result
    assign flags_out = done ? '0 : f;
    assign depth_out = done ? '0 : depth;
    assign count_out = done ? '0 : count_b;

    assign res.content       = content;
    assign res.ends_element  = ends;
    assign res.done_res      = done;
    assign res.element_count = 16'(count_b);
    assign res.status        = status;

endmodule

### tb/tb_bracketed_array_element_splitter.sv
module tb_bracketed_array_element_splitter;
    import bae_pkg::*;

    localparam int DEPTH_BITS  = 8;
    localparam int COUNT_BITS  = 16;
    localparam int DEPTH_MAX   = (1 << (DEPTH_BITS - 1)) - 1;
    localparam int DEPTH_MIN   = -DEPTH_MAX - 1;
    localparam int COUNT_TOP   = (1 << COUNT_BITS) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic        s_tlast = 1'b0; // last
    logic [1:0]  s_tuser = '0;   // [0] first, [1] empty_field
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [15:0] element_count, [18:16] status
    logic        m_tlast;        // done_res
    logic [1:0]  m_tuser;        // [0] content, [1] ends_element

    bracketed_array_element_splitter #(
        .DEPTH_BITS (DEPTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Splitter configuration and per-field state mirrored by the predictor
    logic [7:0] cfg_delim = DELIM_RESET;
    logic       cfg_mode = MODE_BRACKET;
    bit         quote_on;
    int         nest_depth;
    int         elem_count;
    bit         inner_seen;
    bit         segment_open;
    bit         frame_bad;
    bit         depth_ovf;

    // Stimulus and expected results
    item_t      bytes_to_send[$];
    result_t    results_due[$];
    item_t      held_item;
    bit         idle_on = 1'b1;
    int         send_gap = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         hold_req = 0;
    int         hold_served = 0;
    int         bytes_pushed = 0;
    int         bytes_taken = 0;
    int         results_checked = 0;
    int         fields_closed = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    function void clear_field_state();
        quote_on     = 1'b0;
        nest_depth   = 0;
        elem_count   = 0;
        inner_seen   = 1'b0;
        segment_open = 1'b0;
        frame_bad    = 1'b0;
        depth_ovf    = 1'b0;
    endfunction

    function void bump_count();
        if (elem_count < COUNT_TOP)
            elem_count++;
    endfunction

    // Nesting depth saturates at its signed limits and flags the overflow
    function void move_depth(bit up);
        if (up)
        begin
            if (nest_depth >= DEPTH_MAX)
                depth_ovf = 1'b1;
            else
                nest_depth++;
        end
        else
        begin
            if (nest_depth <= DEPTH_MIN)
                depth_ovf = 1'b1;
            else
                nest_depth--;
        end
    endfunction

    // Classify one byte and advance the field state
    function automatic result_t split_byte(item_t it);
        result_t r;
        r = '0;
        if (it.first)
            clear_field_state();
        if (it.empty_field)
        begin
            r.done_res = 1'b1;
            if (cfg_mode == MODE_BRACKET)
                frame_bad = 1'b1;
            else if (segment_open)
            begin
                r.ends_element = 1'b1;
                bump_count();
                segment_open = 1'b0;
            end
        end
        else if (cfg_mode == MODE_HIVE)
        begin
            if (it.data_byte == cfg_delim)
            begin
                r.ends_element = 1'b1;
                bump_count();
                segment_open = 1'b0;
            end
            else
            begin
                r.content = 1'b1;
                segment_open = 1'b1;
            end
            if (it.last)
            begin
                r.done_res = 1'b1;
                if (segment_open)
                begin
                    r.ends_element = 1'b1;
                    bump_count();
                    segment_open = 1'b0;
                end
            end
        end
        else if (it.first)
        begin
            if (it.data_byte != CHAR_LBRACKET)
                frame_bad = 1'b1;
            if (it.last)
            begin
                frame_bad = 1'b1;
                r.done_res = 1'b1;
            end
        end
        else if (it.last)
        begin
            if (it.data_byte != CHAR_RBRACKET)
                frame_bad = 1'b1;
            if (inner_seen)
                r.ends_element = 1'b1;
            r.done_res = 1'b1;
        end
        else
        begin
            if (!inner_seen)
            begin
                inner_seen = 1'b1;
                bump_count();
            end
            r.content = 1'b1;
            if (it.data_byte == CHAR_QUOTE)
                quote_on = !quote_on;
            else if (!quote_on && it.data_byte == CHAR_LBRACKET)
                move_depth(1'b1);
            else if (!quote_on && it.data_byte == CHAR_RBRACKET)
                move_depth(1'b0);
            else if (!quote_on && nest_depth == 0 && it.data_byte == cfg_delim)
            begin
                r.content = 1'b0;
                r.ends_element = 1'b1;
                bump_count();
            end
        end
        r.element_count = elem_count[15:0];
        if (r.done_res)
        begin
            r.status = STATUS_OK;
            if (cfg_mode == MODE_BRACKET)
            begin
                if (frame_bad)
                    r.status = STATUS_FRAMING;
                else if (depth_ovf)
                    r.status = STATUS_DEPTH_OVF;
                else if (nest_depth != 0)
                    r.status = STATUS_UNBALANCED;
                else if (quote_on)
                    r.status = STATUS_OPEN_QUOTE;
            end
            clear_field_state();
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; none when idling is off
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // Input driver: predicts each accepted byte, then offers the next one
    always @(posedge clk)
    begin
        item_t nxt;
        if (s_tvalid && s_tready)
        begin
            results_due.insert(results_due.size(), split_byte(held_item));
            bytes_taken++;
        end
        if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (bytes_to_send.size() > 0)
            begin
                nxt = bytes_to_send.pop_front();
                held_item = nxt;
                s_tdata  <= nxt.data_byte;
                s_tlast  <= nxt.last;
                s_tuser  <= {nxt.empty_field, nxt.first};
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got.content       = m_tuser[0];
            got.ends_element  = m_tuser[1];
            got.done_res      = m_tlast;
            got.element_count = m_tdata[15:0];
            got.status        = m_tdata[18:16];
            if (got.done_res)
                fields_closed++;
            if (results_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: c=%0b e=%0b d=%0b cnt=%0d st=%0d",
                             got.content, got.ends_element, got.done_res,
                             got.element_count, got.status);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display({"result %0d: got c=%0b e=%0b d=%0b cnt=%0d st=%0d, ",
                                  "expected c=%0b e=%0b d=%0b cnt=%0d st=%0d"},
                                 results_checked, got.content, got.ends_element,
                                 got.done_res, got.element_count, got.status,
                                 want.content, want.ends_element, want.done_res,
                                 want.element_count, want.status);
                    mismatches++;
                end
            end
            results_checked++;
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_served)
        begin
            hold_served <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b, bit f, bit l, bit e);
        item_t x;
        x.data_byte   = b;
        x.first       = f;
        x.last        = l;
        x.empty_field = e;
        bytes_to_send.insert(bytes_to_send.size(), x);
        bytes_pushed++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == 0, i == s.len() - 1, 1'b0);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic apb_write(logic reg_idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_DELIMITER)
            cfg_delim = value[7:0];
        else
            cfg_mode = value[0];
    endtask

    // Wait until every queued byte is taken and its result checked
    task automatic wait_drained();
        while (bytes_taken != bytes_pushed || results_checked != bytes_pushed)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] delim, logic md);
        wait_drained();
        apb_write(REG_DELIMITER, {24'h0, delim});
        apb_write(REG_MODE, {31'h0, md});
    endtask

    // Bracketed field with random elements, quotes and nesting; some are broken
    task automatic bracket_field();
        int n;
        int r;
        int shape;
        int depth;
        bit q;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 8);
        if (shape < 4)
            push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        else if (shape < 7)
            push_byte(CHAR_LBRACKET, 1'b0, 1'b0, 1'b0);
        else
            push_byte(CHAR_LBRACKET, 1'b1, 1'b0, 1'b0);
        depth = 0;
        q = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                b = 8'h61 + 8'($urandom_range(0, 25));
            else if (r < 58)
                b = cfg_delim;
            else if (r < 68)
            begin
                b = CHAR_QUOTE;
                q = !q;
            end
            else if (r < 78)
            begin
                b = CHAR_LBRACKET;
                if (!q)
                    depth++;
            end
            else if (r < 86 && depth > 0)
            begin
                b = CHAR_RBRACKET;
                if (!q)
                    depth--;
            end
            else
                b = 8'($urandom_range(0, 255));
            push_byte(b, 1'b0, 1'b0, 1'b0);
        end
        // usually close whatever is still open
        if ($urandom_range(0, 9) != 0)
        begin
            if (q)
                push_byte(CHAR_QUOTE, 1'b0, 1'b0, 1'b0);
            for (; depth > 0; depth--)
                push_byte(CHAR_RBRACKET, 1'b0, 1'b0, 1'b0);
        end
        if (shape < 10)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
        else if (shape < 14)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
        else if (shape >= 16)
            push_byte(CHAR_RBRACKET, 1'b0, 1'b1, 1'b0);
        // otherwise no closing byte: the field runs into the next one
    endtask

    // Plain delimited field; some are empty, cut short or lack a first mark
    task automatic hive_field();
        int n;
        int shape;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            push_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 8);
        for (int i = 0; i <= n; i++)
        begin
            b = ($urandom_range(0, 2) == 0) ? cfg_delim : 8'($urandom_range(0, 255));
            push_byte(b, i == 0 && shape >= 12, i == n && shape >= 20, 1'b0);
        end
        if (shape >= 12 && shape < 20)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic noise_items(int n);
        repeat (n)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
    endtask

    // Mostly well-formed fields for the current mode, some noise
    task automatic fill_random(int target);
        int start;
        start = bytes_pushed;
        while (bytes_pushed - start < target)
        begin
            if ($urandom_range(0, 9) == 0)
                noise_items($urandom_range(1, 4));
            else if (cfg_mode == MODE_HIVE)
                hive_field();
            else
                bracket_field();
        end
    endtask

    // Nesting driven past the signed depth limit, upward or downward
    task automatic deep_field(bit up);
        push_byte(CHAR_LBRACKET, 1'b1, 1'b0, 1'b0);
        repeat (DEPTH_MAX + 3)
            push_byte(up ? CHAR_LBRACKET : CHAR_RBRACKET, 1'b0, 1'b0, 1'b0);
        push_byte(CHAR_RBRACKET, 1'b0, 1'b1, 1'b0);
    endtask

    // Main sequence
    initial
    begin
        clear_field_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Bracketed directed: empty list, quoted delimiter, nesting, framing,
        // negative depth, open quote, bytes without a first mark
        set_config(DELIM_RESET, MODE_BRACKET);
        push_text("[]");
        push_text("[\",\",[a,b]]");
        push_byte(CHAR_LBRACKET, 1'b1, 1'b1, 1'b0);
        push_byte(8'hA5, 1'b1, 1'b0, 1'b1);
        push_text("[]]");
        push_text("[\"]");
        push_byte(8'h61, 1'b0, 1'b0, 1'b0);
        push_byte(DELIM_RESET, 1'b0, 1'b0, 1'b0);
        push_byte(CHAR_RBRACKET, 1'b0, 1'b1, 1'b0);

        // Hive directed: trailing empty element, empty field mid-field
        set_config(8'h3B, MODE_HIVE);
        push_text("a;;b;");
        push_byte(8'h78, 1'b1, 1'b0, 1'b0);
        push_byte(8'h3B, 1'b0, 1'b0, 1'b0);
        push_byte(8'h79, 1'b0, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b1, 1'b1);

        // Random bracketed with a long receiver hold while bytes keep coming
        set_config(DELIM_RESET, MODE_BRACKET);
        hold_req++;
        fill_random(250);

        // Delimiter equal to a bracket, and depth overflow both ways
        set_config(CHAR_LBRACKET, MODE_BRACKET);
        deep_field(1'b1);
        deep_field(1'b0);
        fill_random(50);
        set_config(CHAR_QUOTE, MODE_BRACKET);
        fill_random(60);

        // Delimiter extremes, first stretch with no idling at all
        idle_on = 1'b0;
        set_config(8'h00, MODE_BRACKET);
        fill_random(150);
        idle_on = 1'b1;
        set_config(8'hFF, MODE_BRACKET);
        fill_random(150);

        // Hive mode with several delimiters
        set_config(DELIM_RESET, MODE_HIVE);
        fill_random(250);
        set_config(8'h00, MODE_HIVE);
        fill_random(80);
        set_config(8'hFF, MODE_HIVE);
        fill_random(80);

        // Random settings
        repeat (5)
        begin
            set_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            fill_random(50);
        end
        set_config(DELIM_RESET, MODE_BRACKET);
        fill_random(30);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes, checked %0d results over %0d closed fields", bytes_taken,
                 results_checked, fields_closed);
        $display("Covered bracketed and Hive splitting, delimiter extremes and depth limits");
        if (mismatches == 0 && results_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
